FILE: hw/rtl/bed_pkg.sv
// Shared types and constants of the backslash escape decoder.
`timescale 1ns / 1ps

package bed_pkg;

	// Default depth of the run queue between the front and the back end.
	localparam int unsigned QUEUE_DEPTH = 4;

	// Largest number of result items that one input item can cause.
	localparam int unsigned RUN_MAX = 5;

	// Values of the dialect register.
	localparam logic DIALECT_FORMAT = 1'b0;
	localparam logic DIALECT_ARG    = 1'b1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       stop;
		logic       last_of_run;
	} out_item_t;

	typedef logic [$clog2(RUN_MAX + 1)-1:0] run_cnt_t;
	typedef logic [$clog2(RUN_MAX)-1:0]     run_idx_t;

	// All result bytes caused by one input item, oldest in data[0].
	typedef struct packed {
		logic                      stop;
		run_cnt_t                  count;
		logic [RUN_MAX-1:0][7:0]   data;
	} run_t;

endpackage

FILE: hw/rtl/backslash_escape_decoder.sv
// Top level of the backslash escape decoder.
`timescale 1ns / 1ps

// Channel   Handshake        Payload                               Accepted when
// input     push / full      in_item  (in_byte, end_of_string)     push && !full
// result    empty / pop      out_item (out_byte, stop, last_of_run) pop && !empty
// config    cfg_we           cfg_data (dialect)                    cfg_we
//
// An item is accepted every cycle while the run queue has room, and the front end
// decodes it in that cycle into one run of up to five result bytes. The back end
// hands out one result item per cycle from its output register while the result
// side pops; a run goes through the run queue and then the output register on its
// way to the result ports. Reset clears the escape state, the dialect, the queue
// and the output register. A stalled result side fills the queue and raises full.

module backslash_escape_decoder
	import bed_pkg::*;
#(
	parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  in_item,
	output logic      empty,
	input  logic      pop,
	output out_item_t out_item,
	input  logic      cfg_we,
	input  logic      cfg_data
);

	logic run_push, run_valid, run_pop, q_full;
	run_t run_in, run_out;

	// The input side stalls only on a full run queue.
	assign full = q_full;

	// Front end: escape state machine and run builder.
	bed_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_accept (push && !q_full),
		.in_item   (in_item),
		.run_push  (run_push),
		.run_data  (run_in)
	);

	// Runs wait here so that either side can stall on its own.
	bed_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (run_push),
		.wr_data  (run_in),
		.full     (q_full),
		.rd_valid (run_valid),
		.rd_data  (run_out),
		.rd_en    (run_pop)
	);

	// Back end: one result item per cycle while the result side pops.
	bed_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.run_valid (run_valid),
		.run_data  (run_out),
		.run_pop   (run_pop),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

endmodule

FILE: hw/rtl/bed_front.sv
// Front end: accepts input items, tracks the escape state and builds result runs.
`timescale 1ns / 1ps

module bed_front
	import bed_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     cfg_data,
	input  logic     in_accept,
	input  in_item_t in_item,
	output logic     run_push,
	output run_t     run_data
);

	typedef enum logic [2:0] {
		PH_PLAIN,
		PH_ESC,
		PH_OCT,
		PH_HX,
		PH_HU,
		PH_HBU
	} phase_t;

	typedef struct packed {
		logic [2:0]      n;
		logic [3:0][7:0] b;
	} fin_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_7      = 8'h37;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF     = 8'h66;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_C      = 8'h63;
	localparam logic [7:0] CH_E      = 8'h65;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_V      = 8'h76;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_BIGU   = 8'h55;

	// Returns a valid flag above the digit value.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c inside {[CH_0:CH_9]}) begin
			r = {1'b1, c[3:0]};
		end else if (c inside {[CH_LA:CH_LF], [CH_UA:CH_UF]}) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// Bytes that close a pending digit escape.
	function automatic fin_t finish(input phase_t ph, input logic [31:0] v,
			input logic [3:0] cnt);
		fin_t f;
		f = '0;
		case (ph)
			PH_OCT: begin
				f.n = 3'd1;
				f.b[0] = v[7:0];
			end
			PH_HX, PH_HU, PH_HBU: begin
				if (cnt == 4'd0) begin
					f.n = 3'd2;
					f.b[0] = CH_BSLASH;
					f.b[1] = (ph == PH_HX) ? CH_X : ((ph == PH_HU) ? CH_U : CH_BIGU);
				end else if (ph == PH_HX) begin
					f.n = 3'd1;
					f.b[0] = v[7:0];
				end else if (v < 32'h80) begin
					f.n = 3'd1;
					f.b[0] = v[7:0];
				end else if (v < 32'h800) begin
					f.n = 3'd2;
					f.b[0] = {3'b110, v[10:6]};
					f.b[1] = {2'b10, v[5:0]};
				end else if (v < 32'h10000) begin
					f.n = 3'd3;
					f.b[0] = {4'b1110, v[15:12]};
					f.b[1] = {2'b10, v[11:6]};
					f.b[2] = {2'b10, v[5:0]};
				end else if (v < 32'h110000) begin
					f.n = 3'd4;
					f.b[0] = {5'b11110, v[20:18]};
					f.b[1] = {2'b10, v[17:12]};
					f.b[2] = {2'b10, v[11:6]};
					f.b[3] = {2'b10, v[5:0]};
				end
			end
			default: begin
				f = '0;
			end
		endcase
		return f;
	endfunction

	phase_t      phase_q, phase_n, fin_ph;
	logic [31:0] acc_q, acc_n;
	logic [3:0]  cnt_q, cnt_n, cnt_d, limit;
	logic        stopped_q, stopped_n;
	logic        dialect_q;
	logic [4:0]  hv;
	logic        fresh, mid_fin, is_stop;
	logic [7:0]  b;
	logic        eos;
	fin_t        fin;
	run_t        run;
	run_cnt_t    n;

	assign b   = in_item.in_byte;
	assign eos = in_item.end_of_string;
	assign hv  = hex_val(b);

	always_comb begin
		case (phase_q)
			PH_HX:   limit = 4'd2;
			PH_HU:   limit = 4'd4;
			default: limit = 4'd8;
		endcase
	end

	always_comb begin
		run       = '0;
		n         = '0;
		phase_n   = phase_q;
		acc_n     = acc_q;
		cnt_n     = cnt_q;
		stopped_n = stopped_q;
		fresh     = 1'b1;
		mid_fin   = 1'b0;
		is_stop   = 1'b0;
		cnt_d     = cnt_q + 4'd1;
		fin_ph    = phase_q;
		fin       = '0;

		// Stage one: the state that was waiting for this byte.
		case (phase_q)
			PH_OCT: begin
				mid_fin = 1'b1;
				if (b inside {[CH_0:CH_7]}) begin
					acc_n   = {acc_q[28:0], b[2:0]};
					cnt_n   = cnt_d;
					fresh   = 1'b0;
					mid_fin = (cnt_d >= 4'd3);
				end
			end
			PH_HX, PH_HU, PH_HBU: begin
				mid_fin = 1'b1;
				if (hv[4]) begin
					acc_n   = {acc_q[27:0], hv[3:0]};
					cnt_n   = cnt_d;
					fresh   = 1'b0;
					mid_fin = (cnt_d >= limit);
				end
			end
			PH_ESC: begin
				fresh   = 1'b0;
				phase_n = PH_PLAIN;
				acc_n   = '0;
				cnt_n   = '0;
				n       = run_cnt_t'(1);
				case (b)
					CH_BSLASH: run.data[0] = CH_BSLASH;
					CH_A:      run.data[0] = 8'h07;
					CH_B:      run.data[0] = 8'h08;
					CH_E:      run.data[0] = 8'h1B;
					CH_F:      run.data[0] = 8'h0C;
					CH_N:      run.data[0] = 8'h0A;
					CH_R:      run.data[0] = 8'h0D;
					CH_T:      run.data[0] = 8'h09;
					CH_V:      run.data[0] = 8'h0B;
					CH_C:      is_stop = 1'b1;
					default: begin
						if (dialect_q == DIALECT_FORMAT && b == CH_QUOTE) begin
							run.data[0] = CH_QUOTE;
						end else if (dialect_q == DIALECT_FORMAT &&
								b >= CH_0 && b <= CH_7) begin
							n       = '0;
							phase_n = PH_OCT;
							acc_n   = {29'd0, b[2:0]};
							cnt_n   = 4'd1;
						end else if (dialect_q == DIALECT_ARG && b == CH_0) begin
							n       = '0;
							phase_n = PH_OCT;
						end else if (dialect_q == DIALECT_FORMAT && b == CH_X) begin
							n       = '0;
							phase_n = PH_HX;
						end else if (dialect_q == DIALECT_FORMAT && b == CH_U) begin
							n       = '0;
							phase_n = PH_HU;
						end else if (dialect_q == DIALECT_FORMAT && b == CH_BIGU) begin
							n       = '0;
							phase_n = PH_HBU;
						end else begin
							run.data[0] = CH_BSLASH;
							run.data[1] = b;
							n           = run_cnt_t'(2);
						end
					end
				endcase
			end
			default: begin
				fresh = 1'b1;
			end
		endcase

		// Stage two: close a digit escape, either on its own or at end of string.
		// Only one of the two can produce bytes in a step, and neither leaves
		// a fresh byte ahead of it.
		if (mid_fin || eos) begin
			fin_ph = mid_fin ? phase_q : phase_n;
			fin    = finish(fin_ph, acc_n, cnt_n);
			for (int k = 0; k < 4; k++) begin
				if (3'(k) < fin.n) begin
					run.data[run_idx_t'(n)] = fin.b[k];
					n = n + run_cnt_t'(1);
				end
			end
		end
		if (mid_fin) begin
			phase_n = PH_PLAIN;
			acc_n   = '0;
			cnt_n   = '0;
		end

		// Stage three: the byte taken as plain text.
		if (fresh) begin
			if (b == CH_BSLASH && !eos) begin
				phase_n = PH_ESC;
			end else begin
				run.data[run_idx_t'(n)] = b;
				n = n + run_cnt_t'(1);
			end
		end

		if (eos) begin
			phase_n = PH_PLAIN;
			acc_n   = '0;
			cnt_n   = '0;
		end

		if (is_stop) begin
			run       = '0;
			run.stop  = 1'b1;
			n         = run_cnt_t'(1);
			stopped_n = 1'b1;
		end
		run.count = n;
	end

	assign run_data = run;
	assign run_push = in_accept && !stopped_q && (n != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PLAIN;
			acc_q     <= '0;
			cnt_q     <= '0;
			stopped_q <= 1'b0;
			dialect_q <= DIALECT_FORMAT;
		end else begin
			if (cfg_we) begin
				dialect_q <= cfg_data;
			end
			if (in_accept && !stopped_q) begin
				phase_q   <= phase_n;
				acc_q     <= acc_n;
				cnt_q     <= cnt_n;
				stopped_q <= stopped_n;
			end
		end
	end

endmodule

FILE: hw/rtl/bed_queue.sv
// Run queue between the front end and the back end.
`timescale 1ns / 1ps

module bed_queue
	import bed_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  run_t wr_data,
	output logic full,
	output logic rd_valid,
	output run_t rd_data,
	input  logic rd_en
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	run_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full     = (cnt_q == FULL_CNT);
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/bed_back.sv
// Back end: takes runs apart into single result items behind an output register.
`timescale 1ns / 1ps

module bed_back
	import bed_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      run_valid,
	input  run_t      run_data,
	output logic      run_pop,
	output logic      empty,
	input  logic      pop,
	output out_item_t out_item
);

	run_idx_t  idx_q;
	logic      valid_q;
	out_item_t out_q;
	logic      load, last;

	assign load    = !valid_q || pop;
	assign last    = ((run_cnt_t'(idx_q) + run_cnt_t'(1)) == run_data.count);
	assign run_pop = load && run_valid && last;
	assign empty   = !valid_q;
	assign out_item = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= run_valid;
			if (run_valid) begin
				idx_q <= last ? '0 : idx_q + run_idx_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && run_valid) begin
			out_q.out_byte    <= run_data.data[idx_q];
			out_q.stop        <= run_data.stop;
			out_q.last_of_run <= last;
		end
	end

endmodule

FILE: verif/tb_backslash_escape_decoder.sv
// Self-checking testbench for the backslash escape decoder, with its own decoding predictor.
`timescale 1ns / 1ps

module tb_backslash_escape_decoder;
	import bed_pkg::*;

	// The run is cut off here whatever happens, with plenty of margin over the slowest correct run.
	localparam int unsigned CYCLE_LIMIT = 200000;

	// Control bytes that the simple escapes decode to.
	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_ESC = 8'h1b;
	localparam logic [7:0] CH_FF  = 8'h0c;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_VT  = 8'h0b;

	// Where the decoder is within an escape sequence.
	typedef enum logic [2:0] {
		ST_TEXT,
		ST_ESCAPE,
		ST_OCTAL,
		ST_HEX_X,
		ST_HEX_U,
		ST_HEX_BIG_U
	} esc_phase_e;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  in_item;
	logic      empty;
	logic      pop;
	out_item_t out_item;
	logic      cfg_we;
	logic      cfg_data;

	// Predictor state. It follows the block item by item, updated at the edge
	// where each input item is accepted.
	esc_phase_e  esc_phase;
	logic [31:0] esc_acc;
	logic [3:0]  esc_digits;
	logic        halted;
	logic        dialect_q;

	// Bytes decoded from the item being predicted, and all decoded output items
	// that have not yet come out of the block, oldest first.
	out_item_t run_q[$];
	out_item_t decoded_q[$];

	int  failures;
	int  reported;
	int  hold_left;
	int  cycle_count;
	bit  steady;

	backslash_escape_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void emit(input logic [7:0] b);
		out_item_t r;
		r.out_byte    = b;
		r.stop        = 1'b0;
		r.last_of_run = 1'b0;
		run_q.push_back(r);
	endfunction

	function automatic int hex_value(input logic [7:0] b);
		if (b >= "0" && b <= "9") return int'(b - "0");
		if (b >= "a" && b <= "f") return int'(b - "a") + 10;
		if (b >= "A" && b <= "F") return int'(b - "A") + 10;
		return -1;
	endfunction

	// UTF-8 of one code point; code points past the Unicode range give nothing.
	function automatic void emit_utf8(input logic [31:0] v);
		if (v < 32'h80) begin
			emit(v[7:0]);
		end else if (v < 32'h800) begin
			emit(8'hC0 | 8'(v >> 6));
			emit(8'h80 | {2'b00, v[5:0]});
		end else if (v < 32'h10000) begin
			emit(8'hE0 | 8'(v >> 12));
			emit(8'h80 | {2'b00, v[11:6]});
			emit(8'h80 | {2'b00, v[5:0]});
		end else if (v < 32'h110000) begin
			emit(8'hF0 | 8'(v >> 18));
			emit(8'h80 | {2'b00, v[17:12]});
			emit(8'h80 | {2'b00, v[11:6]});
			emit(8'h80 | {2'b00, v[5:0]});
		end
	endfunction

	// Ends a digit escape with whatever it collected and goes back to text.
	function automatic void close_escape();
		case (esc_phase)
		ST_OCTAL: emit(esc_acc[7:0]);
		ST_HEX_X, ST_HEX_U, ST_HEX_BIG_U: begin
			if (esc_digits == 0) begin
				// No digit at all: the escape comes out as it was written.
				emit("\\");
				emit(esc_phase == ST_HEX_X ? "x" : (esc_phase == ST_HEX_U ? "u" : "U"));
			end else if (esc_phase == ST_HEX_X) begin
				emit(esc_acc[7:0]);
			end else begin
				emit_utf8(esc_acc);
			end
		end
		default: ;
		endcase
		esc_phase  = ST_TEXT;
		esc_acc    = '0;
		esc_digits = '0;
	endfunction

	// Works out the output items of one accepted input item and queues them.
	function automatic void decode_byte(input in_item_t it);
		logic [7:0] b;
		logic       eos;
		logic       fresh;
		int         h;
		int         lim;
		out_item_t  r;
		b     = it.in_byte;
		eos   = it.end_of_string;
		fresh = 1'b1;
		if (halted) return;
		run_q = {};
		case (esc_phase)
		ST_OCTAL: begin
			if (b >= "0" && b <= "7") begin
				esc_acc    = esc_acc * 32'd8 + 32'(b - "0");
				esc_digits = esc_digits + 4'd1;
				fresh      = 1'b0;
				if (esc_digits >= 3) close_escape();
			end else begin
				close_escape();
			end
		end
		ST_HEX_X, ST_HEX_U, ST_HEX_BIG_U: begin
			h   = hex_value(b);
			lim = (esc_phase == ST_HEX_X) ? 2 : ((esc_phase == ST_HEX_U) ? 4 : 8);
			if (h >= 0) begin
				esc_acc    = esc_acc * 32'd16 + 32'(h);
				esc_digits = esc_digits + 4'd1;
				fresh      = 1'b0;
				if (esc_digits >= lim) close_escape();
			end else begin
				close_escape();
			end
		end
		ST_ESCAPE: begin
			fresh      = 1'b0;
			esc_phase  = ST_TEXT;
			esc_acc    = '0;
			esc_digits = '0;
			case (b)
			"\\": emit("\\");
			"a":  emit(CH_BEL);
			"b":  emit(CH_BS);
			"e":  emit(CH_ESC);
			"f":  emit(CH_FF);
			"n":  emit(CH_LF);
			"r":  emit(CH_CR);
			"t":  emit(CH_TAB);
			"v":  emit(CH_VT);
			"c": begin
				// Stop: one result, then the block is dead until reset.
				halted        = 1'b1;
				r.out_byte    = 8'h00;
				r.stop        = 1'b1;
				r.last_of_run = 1'b1;
				decoded_q.push_back(r);
				return;
			end
			default: begin
				if (dialect_q == DIALECT_FORMAT && b == "\"") begin
					emit("\"");
				end else if (dialect_q == DIALECT_FORMAT && b >= "0" && b <= "7") begin
					esc_phase  = ST_OCTAL;
					esc_acc    = 32'(b - "0");
					esc_digits = 4'd1;
				end else if (dialect_q == DIALECT_ARG && b == "0") begin
					esc_phase = ST_OCTAL;
				end else if (dialect_q == DIALECT_FORMAT && b == "x") begin
					esc_phase = ST_HEX_X;
				end else if (dialect_q == DIALECT_FORMAT && b == "u") begin
					esc_phase = ST_HEX_U;
				end else if (dialect_q == DIALECT_FORMAT && b == "U") begin
					esc_phase = ST_HEX_BIG_U;
				end else begin
					emit("\\");
					emit(b);
				end
			end
			endcase
		end
		default: ;
		endcase

		// A plain byte, or one that ended a digit escape, is decoded here as new text.
		if (fresh) begin
			if (b == "\\") begin
				if (eos) emit("\\");
				else esc_phase = ST_ESCAPE;
			end else begin
				emit(b);
			end
		end

		if (eos) close_escape();

		foreach (run_q[i]) begin
			r = run_q[i];
			r.last_of_run = (i == run_q.size() - 1);
			decoded_q.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------
	// Result side: random pops, the long hold-off, and the checker
	// ------------------------------------------------------------------

	// The hold-off is counted here in cycles; a test only loads hold_left.
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				pop = 1'b0;
			end else begin
				pop = steady || ($urandom_range(99) >= 31);
			end
		end
	end

	// Every accepted result must match the oldest decoded byte still owed.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (decoded_q.size() == 0) begin
				failures = failures + 1;
				if (reported < 10)
					$display("unexpected result: byte %02h stop %0b last %0b",
						out_item.out_byte, out_item.stop, out_item.last_of_run);
				reported = reported + 1;
			end else begin
				want = decoded_q.pop_front();
				if (out_item.out_byte !== want.out_byte || out_item.stop !== want.stop ||
						out_item.last_of_run !== want.last_of_run) begin
					failures = failures + 1;
					if (reported < 10)
						$display("mismatch: expected byte %02h stop %0b last %0b,",
							want.out_byte, want.stop, want.last_of_run,
							" got byte %02h stop %0b last %0b",
							out_item.out_byte, out_item.stop, out_item.last_of_run);
					reported = reported + 1;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count = cycle_count + 1;
		end
		$display("tb_backslash_escape_decoder: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Input side. Every task here is entered just after a falling edge and
	// returns just after one, so push can stay high from one item to the next.
	// ------------------------------------------------------------------

	task automatic send_byte(input logic [7:0] b, input logic eos);
		in_item_t it;
		it.in_byte       = b;
		it.end_of_string = eos;
		while (!steady && $urandom_range(99) < 31) begin
			push = 1'b0;
			@(negedge clk);
		end
		push    = 1'b1;
		in_item = it;
		@(posedge clk);
		while (full) @(posedge clk);
		decode_byte(it);
		@(negedge clk);
	endtask

	// Sends the characters of s; the last one carries end_of_string if asked.
	task automatic send_text(input string s, input logic eos_last);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eos_last && (i == s.len() - 1));
	endtask

	// Stops sending until every owed result has come out.
	task automatic wait_drained();
		push = 1'b0;
		while (decoded_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_dialect(input logic v);
		wait_drained();
		cfg_we   = 1'b1;
		cfg_data = v;
		@(negedge clk);
		cfg_we    = 1'b0;
		dialect_q = v;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'("0") + 8'(n);
		return ($urandom_range(1) ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
	endfunction

	// Random text built mostly from whole escape sequences with random digits,
	// mixed with plain bytes and a share of raw noise. The end of string mark
	// falls at random, so it also cuts escapes short.
	task automatic send_random_text(input int n_items);
		logic [7:0]  tok[$];
		logic [7:0]  b;
		logic [31:0] val;
		int          sel;
		int          nd;
		int          sent;
		string       simple;
		sent   = 0;
		simple = "\\abefnrtv\"";
		while (sent < n_items) begin
			tok = {};
			sel = $urandom_range(99);
			if (sel < 15) begin
				tok.push_back(8'($urandom_range(255)));
			end else if (sel < 45) begin
				b = 8'($urandom_range(255));
				tok.push_back(b == "\\" ? 8'("/") : b);
			end else begin
				tok.push_back("\\");
				case ($urandom_range(7))
				0: tok.push_back(simple[$urandom_range(simple.len() - 1)]);
				1: begin
					// Octal: in the percent-b dialect only a zero opens it.
					if (dialect_q == DIALECT_ARG) tok.push_back("0");
					nd = $urandom_range(3);
					for (int i = 0; i < nd; i++) tok.push_back(8'("0") + 8'($urandom_range(7)));
				end
				2, 3: begin
					tok.push_back(sel[0] ? "x" : "u");
					nd = $urandom_range(sel[0] ? 2 : 4);
					for (int i = 0; i < nd; i++) tok.push_back(hex_char(4'($urandom_range(15))));
				end
				4: begin
					// About half the values are past the Unicode range.
					tok.push_back("U");
					val = $urandom_range(1) ? 32'($urandom_range(32'h10FFFF)) : $urandom;
					nd  = ($urandom_range(3) == 0) ? $urandom_range(7) : 8;
					for (int i = nd - 1; i >= 0; i--) tok.push_back(hex_char(val[4*i +: 4]));
				end
				5: tok.push_back(8'($urandom_range(255)));
				6: tok.push_back($urandom_range(1) ? 8'h00 : 8'hFF);
				default: tok.push_back("\\");
				endcase
			end
			foreach (tok[i]) begin
				b = tok[i];
				// The stop escape is kept for the end of the run.
				if (esc_phase == ST_ESCAPE && b == "c") b = "d";
				send_byte(b, $urandom_range(11) == 0);
				sent = sent + 1;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Extreme bytes as plain text, and an octal value that overflows a byte.
	task automatic test_plain_and_octal();
		write_dialect(DIALECT_FORMAT);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_text("\\777", 1'b0);
	endtask

	// A hex escape with no digit, and a four-byte code point cut short by a
	// non-digit, which is then decoded as text: five results from one item.
	task automatic test_hex_escapes();
		send_text("\\xq", 1'b0);
		send_text("\\U1F600!", 1'b0);
		send_text("\\U110000", 1'b1);
	endtask

	// The end of string finishes a pending octal escape, and a backslash as
	// the last byte comes out as itself.
	task automatic test_string_end();
		send_text("\\12", 1'b1);
		send_text("\\", 1'b1);
	endtask

	task automatic test_percent_b();
		write_dialect(DIALECT_ARG);
		send_text("\\0101", 1'b0);
	endtask

	// A hex escape begun in the format dialect keeps its own rules after the
	// dialect changes under it.
	task automatic test_dialect_switch();
		write_dialect(DIALECT_FORMAT);
		send_text("\\x4", 1'b0);
		write_dialect(DIALECT_ARG);
		send_text("1", 1'b1);
	endtask

	task automatic test_random_mix(input logic dialect, input int n_items, input bit no_gaps);
		write_dialect(dialect);
		steady = no_gaps;
		send_random_text(n_items);
		steady = 1'b0;
	endtask

	// The result side holds off long enough for the queue to fill and raise
	// full while items keep being offered; then the sender waits for all.
	task automatic test_backpressure();
		hold_left = 150;
		send_random_text(30);
		wait_drained();
	endtask

	// The stop escape gives one stop result; everything after it is dropped.
	task automatic test_stop();
		send_text("\\c", 1'b0);
		send_text("ab", 1'b1);
	endtask

	initial begin
		arst_n     = 1'b0;
		push       = 1'b0;
		in_item    = '0;
		cfg_we     = 1'b0;
		cfg_data   = 1'b0;
		steady     = 1'b0;
		hold_left  = 0;
		failures   = 0;
		reported   = 0;
		esc_phase  = ST_TEXT;
		esc_acc    = '0;
		esc_digits = '0;
		halted     = 1'b0;
		dialect_q  = DIALECT_FORMAT;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_plain_and_octal();
		test_hex_escapes();
		test_string_end();
		test_percent_b();
		test_dialect_switch();
		test_random_mix(DIALECT_FORMAT, 35, 1'b0);
		test_random_mix(DIALECT_ARG, 25, 1'b1);
		test_random_mix(DIALECT_FORMAT, 35, 1'b0);
		test_backpressure();
		test_stop();

		wait_drained();
		repeat (20) @(posedge clk);
		failures = failures + decoded_q.size();
		if (failures == 0) begin
			$display("tb_backslash_escape_decoder: PASS");
		end else begin
			$display("tb_backslash_escape_decoder: FAIL");
		end
		$finish;
	end

endmodule
